### hw/rtl/lrac_pkg.sv
// Shared types and constants for the LRU age-rank key cache.
// Used by lrac_cell and lru_age_rank_preload_cache; no dependencies.
package lrac_pkg;

  // Width of the key and evicted-key ports.
  localparam int KEY_W  = 16;
  // Rank and slot-index fields hold values up to 63, enough for up to 64 entries.
  localparam int RANK_W = 6;

  // FSM states of the top-level sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_COMMIT
  } state_t;

  // Lookup beat that moves down the cell chain, one cell per cycle.
  typedef struct packed {
    logic              active;
    logic [KEY_W-1:0]  key;
    logic              hit;
    logic [RANK_W-1:0] pivot;
    logic              free_found;
    logic [RANK_W-1:0] free_idx;
    logic              ev_found;
    logic [RANK_W-1:0] ev_idx;
    logic [KEY_W-1:0]  ev_key;
  } sweep_t;

  // Update command broadcast to every cell at the end of a lookup.
  typedef struct packed {
    logic              en;
    logic              hit;
    logic [RANK_W-1:0] pivot;
    logic [RANK_W-1:0] slot;
    logic [KEY_W-1:0]  key;
  } update_t;

endpackage

### hw/rtl/lrac_cell.sv
// One cache entry: valid, key and age rank, plus one stage of the lookup chain.
// Depends on lrac_pkg (sweep_t, update_t).
module lrac_cell #(
  parameter int ENTRIES = 20,
  parameter int SKW     = 16,
  parameter int IDX     = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  lrac_pkg::sweep_t sw_in,
  output lrac_pkg::sweep_t sw_out,
  input  lrac_pkg::update_t upd
);

  localparam int AW = $clog2(ENTRIES);

  logic           valid;
  logic [SKW-1:0] key;
  logic [AW-1:0]  age;

  lrac_pkg::sweep_t sw_next;
  logic             match_sw;
  logic             match_upd;
  logic             is_slot;
  logic             younger;

  assign match_sw  = valid && (key == sw_in.key[SKW-1:0]);
  assign match_upd = valid && (key == upd.key[SKW-1:0]);
  assign is_slot   = (upd.slot == lrac_pkg::RANK_W'(IDX));
  assign younger   = age < upd.pivot[AW-1:0];

  always_comb begin
    sw_next = sw_in;
    if (sw_in.active) begin
      if (match_sw) begin
        sw_next.hit   = 1'b1;
        sw_next.pivot = lrac_pkg::RANK_W'(age);
      end
      if (!valid && !sw_in.free_found) begin
        sw_next.free_found = 1'b1;
        sw_next.free_idx   = lrac_pkg::RANK_W'(IDX);
      end
      if (valid && (age == AW'(ENTRIES - 1)) && !sw_in.ev_found) begin
        sw_next.ev_found = 1'b1;
        sw_next.ev_idx   = lrac_pkg::RANK_W'(IDX);
        sw_next.ev_key   = lrac_pkg::KEY_W'(key);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_out <= '0;
    end else begin
      sw_out <= sw_next;
    end
  end

  // Entry state update
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd.en) begin
      if (upd.hit) begin
        if (match_upd) begin
          age <= '0;
        end else if (valid && younger) begin
          age <= age + AW'(1);
        end
      end else begin
        if (is_slot) begin
          valid <= 1'b1;
          key   <= upd.key[SKW-1:0];
          age   <= '0;
        end else if (valid) begin
          age <= age + AW'(1);
        end
      end
    end
  end

endmodule

### hw/rtl/lru_age_rank_preload_cache.sv
// A lookup passes through each cell register, then the summary and result registers.
// The lookup walks the cell chain one cell per cycle, then the commit state updates
//   every cell at once; no new request is taken until the sequencer is back in idle.
// A new request is taken while a finished result still waits on out_stall.
// Reset: synchronous, active high; clears all valid bits and the handshake state.
// Depends on lrac_pkg and lrac_cell.
module lru_age_rank_preload_cache #(
  parameter int ENTRIES  = 20,
  parameter int KEY_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lrac_pkg::KEY_W-1:0] request_key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       hit,
  output logic                       load_needed,
  output logic                       evict_valid,
  output logic [lrac_pkg::KEY_W-1:0] evict_key
);

  // Stored key width: only the low KEY_BITS of the 16-bit key take part, capped at 16.
  localparam int SKW = (KEY_BITS < lrac_pkg::KEY_W) ? KEY_BITS : lrac_pkg::KEY_W;

  lrac_pkg::state_t  state, state_next;
  lrac_pkg::sweep_t  chain [ENTRIES+1];
  lrac_pkg::sweep_t  res;
  lrac_pkg::update_t upd;
  logic              out_free;
  logic              accept;
  logic              evict_now;

  // Output slot can take a new beat this cycle.
  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;

  // Launch beat into the head of the chain.
  always_comb begin
    chain[0]            = '0;
    chain[0].active     = accept;
    chain[0].key        = lrac_pkg::KEY_W'(request_key[SKW-1:0]);
  end

  // Chain of entry cells; each cell checks the beat against its entry and
  // passes it on through its output register.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lrac_cell #(
      .ENTRIES (ENTRIES),
      .SKW     (SKW),
      .IDX     (g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .sw_in  (chain[g]),
      .sw_out (chain[g+1]),
      .upd    (upd)
    );
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      lrac_pkg::ST_IDLE: begin
        if (in_valid) state_next = lrac_pkg::ST_SWEEP;
      end
      lrac_pkg::ST_SWEEP: begin
        if (chain[ENTRIES].active) state_next = lrac_pkg::ST_COMMIT;
      end
      lrac_pkg::ST_COMMIT: begin
        if (out_free) state_next = lrac_pkg::ST_IDLE;
      end
      default: state_next = lrac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Captured lookup summary from the tail of the chain.
  always_ff @(posedge clk) begin
    if (chain[ENTRIES].active) begin
      res <= chain[ENTRIES];
    end
  end

  // A miss evicts only when no slot is free; the evicted slot then takes the key.
  assign evict_now = !res.hit && res.ev_found && !res.free_found;

  // Sequencer: outputs
  always_comb begin
    in_stall  = (state != lrac_pkg::ST_IDLE);
    upd.en    = (state == lrac_pkg::ST_COMMIT) && out_free;
    upd.hit   = res.hit;
    upd.pivot = res.pivot;
    upd.slot  = res.free_found ? res.free_idx : res.ev_idx;
    upd.key   = res.key;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd.en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en) begin
      hit         <= res.hit;
      load_needed <= !res.hit;
      evict_valid <= evict_now;
      evict_key   <= evict_now ? res.ev_key : '0;
    end
  end

endmodule
